[rtl/rcl_pkg.sv]
// Shared types and constants of the repetitive control loop.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rcl_pkg;

  localparam int DATA_W     = 16;
  localparam int CORR_W     = 24;
  localparam int COEF_W     = 16;
  localparam int PERIOD_W   = 9;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;
  localparam int RING_DEPTH = 256;
  localparam int MIN_PERIOD = 2;

  localparam logic [COEF_W-1:0]   FORGET_CAP  = 16'd65470;
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 9'd2;
  localparam logic [DATA_W-1:0]   OUT_MIN_RST = 16'h8000;
  localparam logic [DATA_W-1:0]   OUT_MAX_RST = 16'h7fff;
  localparam logic [CORR_W-1:0]   CORR_POS_SAT = 24'h7fffff;
  localparam logic [CORR_W-1:0]   CORR_NEG_SAT = 24'h800000;

  typedef enum logic [2:0] {
    REG_PERIOD  = 3'd0,
    REG_GAIN    = 3'd1,
    REG_FORGET  = 3'd2,
    REG_OUT_MIN = 3'd3,
    REG_OUT_MAX = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [COEF_W-1:0]   gain;
    logic [COEF_W-1:0]   forget;
    logic [DATA_W-1:0]   out_min;
    logic [DATA_W-1:0]   out_max;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/rcl_cfg_regs.sv]
// Configuration register file behind the APB-style port.
// Depends on rcl_pkg.
`default_nettype none

module rcl_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcl_pkg::APB_AW-1:0]  paddr,
  input  logic [rcl_pkg::APB_DW-1:0]  pwdata,
  output logic [rcl_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output rcl_pkg::cfg_t               cfg_o
);
  import rcl_pkg::*;

  cfg_t                  cfg_q, cfg_d;
  logic                  wr_en;
  logic [APB_AW-3:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_AW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PERIOD:  cfg_d.period  = pwdata[PERIOD_W-1:0];
        REG_GAIN:    cfg_d.gain    = pwdata[COEF_W-1:0];
        REG_FORGET:  cfg_d.forget  = pwdata[COEF_W-1:0];
        REG_OUT_MIN: cfg_d.out_min = pwdata[DATA_W-1:0];
        REG_OUT_MAX: cfg_d.out_max = pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD:  prdata = {{(APB_DW-PERIOD_W){1'b0}}, cfg_q.period};
      REG_GAIN:    prdata = {{(APB_DW-COEF_W){1'b0}}, cfg_q.gain};
      REG_FORGET:  prdata = {{(APB_DW-COEF_W){1'b0}}, cfg_q.forget};
      REG_OUT_MIN: prdata = {{(APB_DW-DATA_W){cfg_q.out_min[DATA_W-1]}}, cfg_q.out_min};
      REG_OUT_MAX: prdata = {{(APB_DW-DATA_W){cfg_q.out_max[DATA_W-1]}}, cfg_q.out_max};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period  <= PERIOD_RST;
      cfg_q.gain    <= '0;
      cfg_q.forget  <= '0;
      cfg_q.out_min <= OUT_MIN_RST;
      cfg_q.out_max <= OUT_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/rcl_ring.sv]
// Correction ring memory: one write port, one registered read port with
// write-through on a same-address collision, and a zeroing sweep after reset.
// Depends on rcl_pkg.
`default_nettype none

module rcl_ring #(
  parameter int unsigned Depth = rcl_pkg::RING_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [$clog2(Depth)-1:0]    rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [$clog2(Depth)-1:0]    wr_addr_i,
  input  logic [rcl_pkg::CORR_W-1:0]  wr_data_i,
  output logic [rcl_pkg::CORR_W-1:0]  rd_data_o,
  output logic                        busy_o
);
  import rcl_pkg::*;

  localparam int AW = $clog2(Depth);

  logic [CORR_W-1:0] mem_q [Depth];
  logic [CORR_W-1:0] rd_q;
  logic [CORR_W-1:0] fwd_q;
  logic              fwd_sel_q;
  logic              clr_q, clr_d;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic              we;
  logic [AW-1:0]     wa;
  logic [CORR_W-1:0] wd;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(Depth - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  assign we = clr_q || wr_en_i;
  assign wa = clr_q ? clr_cnt_q : wr_addr_i;
  assign wd = clr_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      fwd_sel_q <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      if (rd_en_i) begin
        fwd_sel_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_q  <= mem_q[rd_addr_i];
      fwd_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_sel_q ? fwd_q : rd_q;
  assign busy_o    = clr_q;

endmodule

`default_nettype wire

[rtl/rcl_datapath.sv]
// Four-register datapath: products, rounded and saturated correction,
// clamped output. Depends on rcl_pkg.
`default_nettype none

module rcl_datapath #(
  parameter int unsigned Depth = rcl_pkg::RING_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rcl_pkg::cfg_t               cfg_i,
  input  logic                        accept_i,
  input  logic [rcl_pkg::DATA_W-1:0]  error_i,
  input  logic [rcl_pkg::DATA_W-1:0]  base_i,
  input  logic [$clog2(Depth)-1:0]    pos_i,
  input  logic [rcl_pkg::CORR_W-1:0]  old_i,
  output logic                        free_o,
  output logic                        wr_en_o,
  output logic [$clog2(Depth)-1:0]    wr_addr_o,
  output logic [rcl_pkg::CORR_W-1:0]  wr_data_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rcl_pkg::DATA_W-1:0]  out_data_o
);
  import rcl_pkg::*;

  localparam int AW    = $clog2(Depth);
  localparam int POLD_W = COEF_W + CORR_W + 1;
  localparam int PERR_W = COEF_W + DATA_W + 1;
  localparam int SUM_W  = POLD_W + 1;
  localparam int TOT_W  = CORR_W + 1;

  logic                     v1_q, v2_q, v3_q, ov_q;
  logic                     fr_out, fr3, fr2, fr1, mv3, mv2, mv1;

  logic [DATA_W-1:0]        err1_q, base1_q, base2_q, base3_q;
  logic [AW-1:0]            pos1_q, pos2_q;
  logic [COEF_W-1:0]        forget_cap;
  logic signed [POLD_W-1:0] p_old_d, p_old_q;
  logic signed [PERR_W-1:0] p_err_d, p_err_q;
  logic [SUM_W-1:0]         sum, rnd;
  logic [SUM_W-17:0]        shifted;
  logic [CORR_W-1:0]        corr_d, corr3_q;
  logic signed [TOT_W-1:0]  total, lim_max, lim_min, clamped;
  logic [DATA_W-1:0]        out_d, out_q;

  assign fr_out = !ov_q || !out_stall_i;
  assign mv3    = v3_q && fr_out;
  assign fr3    = !v3_q || fr_out;
  assign mv2    = v2_q && fr3;
  assign fr2    = !v2_q || fr3;
  assign mv1    = v1_q && fr2;
  assign fr1    = !v1_q || fr2;

  assign forget_cap = (cfg_i.forget > FORGET_CAP) ? FORGET_CAP : cfg_i.forget;
  assign p_old_d = $signed({1'b0, forget_cap}) * $signed(old_i);
  assign p_err_d = $signed({1'b0, cfg_i.gain}) * $signed(err1_q);

  always_comb begin
    sum     = {{(SUM_W-POLD_W){p_old_q[POLD_W-1]}}, p_old_q}
            + {{(SUM_W-PERR_W-4){p_err_q[PERR_W-1]}}, p_err_q, 4'b0000};
    rnd     = sum + SUM_W'(32768);
    shifted = rnd[SUM_W-1:16];
    if (shifted[SUM_W-17:CORR_W-1] == '0 || shifted[SUM_W-17:CORR_W-1] == '1) begin
      corr_d = shifted[CORR_W-1:0];
    end else if (shifted[SUM_W-17]) begin
      corr_d = CORR_NEG_SAT;
    end else begin
      corr_d = CORR_POS_SAT;
    end
  end

  always_comb begin
    total   = $signed({{(TOT_W-DATA_W){base3_q[DATA_W-1]}}, base3_q})
            + $signed({corr3_q[CORR_W-1], corr3_q});
    lim_max = $signed({{(TOT_W-DATA_W){cfg_i.out_max[DATA_W-1]}}, cfg_i.out_max});
    lim_min = $signed({{(TOT_W-DATA_W){cfg_i.out_min[DATA_W-1]}}, cfg_i.out_min});
    clamped = total;
    if (clamped > lim_max) begin
      clamped = lim_max;
    end
    if (clamped < lim_min) begin
      clamped = lim_min;
    end
    out_d = clamped[DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      v1_q <= accept_i || (v1_q && !fr2);
      v2_q <= mv1 || (v2_q && !fr3);
      v3_q <= mv2 || (v3_q && !fr_out);
      ov_q <= mv3 || (ov_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      err1_q  <= error_i;
      base1_q <= base_i;
      pos1_q  <= pos_i;
    end
    if (mv1) begin
      p_old_q <= p_old_d;
      p_err_q <= p_err_d;
      base2_q <= base1_q;
      pos2_q  <= pos1_q;
    end
    if (mv2) begin
      corr3_q <= corr_d;
      base3_q <= base2_q;
    end
    if (mv3) begin
      out_q <= out_d;
    end
  end

  assign free_o      = fr1;
  assign wr_en_o     = mv2;
  assign wr_addr_o   = pos2_q;
  assign wr_data_o   = corr_d;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/repetitive_control_loop.sv]
// Top level of the repetitive control loop: ring position, handshake,
// configuration port. Uses rcl_pkg, rcl_cfg_regs, rcl_ring, rcl_datapath.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------
//   input    | in_valid_i/in_stall_o  | error_sample_i, base_output_i
//   output   | out_valid_o/out_stall_i| control_output_o
//   config   | psel/penable/pready    | paddr, pwdata, prdata
//
// One item per cycle unless stalled; each item is registered at every stage.
// The ring read is registered at the accepting edge; a correction written at
// that same edge to the same entry is forwarded.
// After reset every ring entry is zeroed; in_stall_o stays high meanwhile.
// The output register holds while stalled; the pipeline fills behind it.
`default_nettype none

module repetitive_control_loop #(
  parameter int unsigned MAX_PERIOD = rcl_pkg::RING_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [rcl_pkg::DATA_W-1:0] error_sample_i,
  input  logic signed [rcl_pkg::DATA_W-1:0] base_output_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rcl_pkg::DATA_W-1:0] control_output_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rcl_pkg::APB_AW-1:0]        paddr,
  input  logic [rcl_pkg::APB_DW-1:0]        pwdata,
  output logic [rcl_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import rcl_pkg::*;

  localparam int AW = $clog2(MAX_PERIOD);
  localparam int CW = (AW + 1 > PERIOD_W) ? AW + 1 : PERIOD_W;

  cfg_t              cfg;
  logic              accept, dp_free, ring_busy;
  logic [CW-1:0]     n_cap, n_use, pos_inc;
  logic [AW-1:0]     pos_q, pos_d, pos_use;
  logic [CORR_W-1:0] old_corr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CORR_W-1:0] wr_data;
  logic [DATA_W-1:0] out_data;

  rcl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    n_cap = (CW'(cfg.period) > CW'(MAX_PERIOD)) ? CW'(MAX_PERIOD) : CW'(cfg.period);
    n_use = (n_cap < CW'(MIN_PERIOD)) ? CW'(MIN_PERIOD) : n_cap;
    pos_use = (CW'(pos_q) >= n_use) ? '0 : pos_q;
    pos_inc = CW'(pos_use) + 1'b1;
    pos_d   = pos_q;
    if (accept) begin
      pos_d = (pos_inc >= n_use) ? '0 : pos_inc[AW-1:0];
    end
  end

  assign accept     = in_valid_i && dp_free && !ring_busy;
  assign in_stall_o = !dp_free || ring_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  rcl_ring #(
    .Depth (MAX_PERIOD)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (pos_use),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (old_corr),
    .busy_o    (ring_busy)
  );

  rcl_datapath #(
    .Depth (MAX_PERIOD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .error_i     (error_sample_i),
    .base_i      (base_output_i),
    .pos_i       (pos_use),
    .old_i       (old_corr),
    .free_o      (dp_free),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign control_output_o = out_data;

endmodule

`default_nettype wire

[rtl/rcl_checker.sv]
// Port-level checks of the repetitive control loop, bound to the top level.
// Depends on rcl_pkg and repetitive_control_loop.
`default_nettype none

module rcl_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [rcl_pkg::DATA_W-1:0]  control_output_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [rcl_pkg::APB_AW-1:0]  paddr,
  input logic [rcl_pkg::APB_DW-1:0]  pwdata,
  input logic [rcl_pkg::APB_DW-1:0]  prdata
);
  import rcl_pkg::*;

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(control_output_o))
    else $error("output item changed while stalled");

  a_period_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[APB_AW-1:2] == REG_PERIOD
    |=> paddr[APB_AW-1:2] != REG_PERIOD || prdata[PERIOD_W-1:0] == $past(pwdata[PERIOD_W-1:0]))
    else $error("period register readback mismatch");

  a_stall_in_reset: assert property (@(posedge clk_i)
    !rst_ni || $rose(rst_ni) |-> !in_valid_i || in_stall_o)
    else $error("item accepted during reset or ring clear");

  a_no_out_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output item shown right after reset");

endmodule

bind repetitive_control_loop rcl_checker u_rcl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .control_output_o (control_output_o),
  .psel             (psel),
  .penable          (penable),
  .pwrite           (pwrite),
  .paddr            (paddr),
  .pwdata           (pwdata),
  .prdata           (prdata)
);

`default_nettype wire

[sim/tb_repetitive_control_loop.sv]
// Self-checking testbench for repetitive_control_loop: directed rows, then random
// phases of settings and samples; outputs checked against model or fixed values.
// Depends on rcl_pkg and the repetitive_control_loop RTL only.
`timescale 1ns / 100ps

module tb_repetitive_control_loop;
  import rcl_pkg::*;

  localparam int PHASES        = 14;
  localparam int PHASE_ITEMS   = 104;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 120;
  localparam int MAX_REPORTS   = 200;
  localparam int TIMEOUT_NS    = 4_000_000;

  localparam logic [APB_AW-1:0] ADDR_SPARE_A = 5'd20;
  localparam logic [APB_AW-1:0] ADDR_SPARE_B = 5'd28;

  typedef enum logic {STEP_ITEM, STEP_WRITE} step_kind_e;

  typedef struct {
    step_kind_e               kind;
    logic [APB_AW-1:0]        addr;
    logic [COEF_W-1:0]        value;
    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W-1:0] base;
    logic signed [DATA_W-1:0] want;
    bit                       typed;
  } step_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] error_sample_i = '0;
  logic signed [DATA_W-1:0] base_output_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] control_output_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_AW-1:0]        paddr = '0;
  logic [APB_DW-1:0]        pwdata = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  logic [PERIOD_W-1:0]      cfg_period = PERIOD_RST;
  logic [COEF_W-1:0]        cfg_gain = '0;
  logic [COEF_W-1:0]        cfg_forget = '0;
  logic signed [DATA_W-1:0] cfg_min = OUT_MIN_RST;
  logic signed [DATA_W-1:0] cfg_max = OUT_MAX_RST;
  logic signed [CORR_W-1:0] corr_store [RING_DEPTH];
  int unsigned              ring_pos = 0;

  logic signed [DATA_W-1:0] pending_control [$];
  step_t                    directed_steps [$];
  int                       fail_count = 0;
  int                       tx_idle_pct = 22;
  int                       rx_stall_pct = 52;
  int                       hold_trigger = 0;
  int                       hold_seen = 0;
  int                       hold_left = 0;

  repetitive_control_loop uut (.*);

  always #4 clk_i = ~clk_i;

  function automatic logic [APB_AW-1:0] reg_addr(input reg_idx_e idx);
    return {idx, 2'b00};
  endfunction

  function automatic logic signed [DATA_W-1:0] next_control(
    input logic signed [DATA_W-1:0] err,
    input logic signed [DATA_W-1:0] base
  );
    int unsigned n;
    int unsigned p;
    longint      q;
    longint      s;
    longint      c;
    longint      total;
    n = cfg_period;
    if (n > RING_DEPTH) n = RING_DEPTH;
    if (n < MIN_PERIOD) n = MIN_PERIOD;
    p = (ring_pos >= n) ? 0 : ring_pos;
    q = (cfg_forget > FORGET_CAP) ? FORGET_CAP : cfg_forget;
    s = q * longint'(corr_store[p]) + longint'(cfg_gain) * longint'(err) * 16;
    c = (s + 32768) >>> 16;
    if (c > longint'($signed(CORR_POS_SAT))) c = longint'($signed(CORR_POS_SAT));
    if (c < longint'($signed(CORR_NEG_SAT))) c = longint'($signed(CORR_NEG_SAT));
    corr_store[p] = c[CORR_W-1:0];
    ring_pos = (p + 1 >= n) ? 0 : p + 1;
    total = longint'(base) + c;
    if (total > longint'(cfg_max)) total = longint'(cfg_max);
    if (total < longint'(cfg_min)) total = longint'(cfg_min);
    return total[DATA_W-1:0];
  endfunction

  function automatic void add_write(input logic [APB_AW-1:0] addr,
                                    input logic [COEF_W-1:0] value);
    step_t st;
    st = '{kind: STEP_WRITE, addr: addr, value: value, err: '0, base: '0, want: '0,
           typed: 1'b0};
    directed_steps.push_back(st);
  endfunction

  function automatic void add_item(input logic signed [DATA_W-1:0] err,
                                   input logic signed [DATA_W-1:0] base,
                                   input logic signed [DATA_W-1:0] want,
                                   input bit typed);
    step_t st;
    st = '{kind: STEP_ITEM, addr: '0, value: '0, err: err, base: base, want: want,
           typed: typed};
    directed_steps.push_back(st);
  endfunction

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [COEF_W-1:0] value);
    logic [APB_DW-1:0] data;
    data = $urandom();
    if (addr[4:2] == REG_PERIOD) data[PERIOD_W-1:0] = value[PERIOD_W-1:0];
    else data[COEF_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (addr[4:2])
      REG_PERIOD:  cfg_period = data[PERIOD_W-1:0];
      REG_GAIN:    cfg_gain = data[COEF_W-1:0];
      REG_FORGET:  cfg_forget = data[COEF_W-1:0];
      REG_OUT_MIN: cfg_min = data[DATA_W-1:0];
      REG_OUT_MAX: cfg_max = data[DATA_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic offer_item(input logic signed [DATA_W-1:0] err,
                            input logic signed [DATA_W-1:0] base,
                            input logic signed [DATA_W-1:0] want,
                            input bit typed);
    logic signed [DATA_W-1:0] predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    error_sample_i <= err;
    base_output_i <= base;
    do @(posedge clk_i); while (in_stall_o);
    predicted = next_control(err, base);
    pending_control.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_control.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_setup(input bit drive_hard);
    logic [PERIOD_W-1:0] period;
    logic [COEF_W-1:0]   gain;
    logic [COEF_W-1:0]   forget;
    logic [DATA_W-1:0]   lo;
    logic [DATA_W-1:0]   hi;
    case ($urandom_range(9))
      0: period = 9'd2;
      1: period = 9'd256;
      2, 3: period = 9'($urandom_range(511));
      default: period = 9'($urandom_range(2, 16));
    endcase
    case ($urandom_range(3))
      0: gain = '0;
      1: gain = 16'hffff;
      2: gain = 16'($urandom());
      default: gain = 16'($urandom_range(8192));
    endcase
    case ($urandom_range(5))
      0: forget = '0;
      1: forget = FORGET_CAP;
      2: forget = 16'hffff;
      3: forget = 16'($urandom_range(65471, 65535));
      4: forget = 16'($urandom());
      default: forget = 16'($urandom_range(60000, 65470));
    endcase
    case ($urandom_range(7))
      6: begin
        lo = 16'($urandom());
        hi = 16'($urandom());
      end
      7: begin
        lo = 16'(-int'($urandom_range(2000)));
        hi = 16'($urandom_range(2000));
      end
      default: begin
        lo = OUT_MIN_RST;
        hi = OUT_MAX_RST;
      end
    endcase
    if (drive_hard) begin
      period = 9'($urandom_range(2, 4));
      gain = 16'($urandom_range(61440, 65535));
    end
    write_reg(reg_addr(REG_PERIOD), 16'(period));
    write_reg(reg_addr(REG_GAIN), gain);
    write_reg(reg_addr(REG_FORGET), forget);
    write_reg(reg_addr(REG_OUT_MIN), lo);
    write_reg(reg_addr(REG_OUT_MAX), hi);
  endtask

  always @(negedge clk_i) begin
    if (hold_seen != hold_trigger) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_output
    logic signed [DATA_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_control.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: control_output expected none, got %0d", $time, control_output_o);
      end else begin
        want = pending_control.pop_front();
        if (control_output_o !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: control_output expected %0d, got %0d", $time, want,
                     control_output_o);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_repetitive_control_loop failed");
    $finish;
  end

  initial begin : stimulus
    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W-1:0] base;
    int                       err_mode;
    foreach (corr_store[i]) corr_store[i] = '0;

    add_item(16'sh7fff, 16'sh8000, 16'sh8000, 1'b1);
    add_item(16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1);
    add_item(16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
    add_item(16'shffff, 16'shffff, 16'shffff, 1'b1);
    add_item(16'sh5555, 16'shaaaa, 16'shaaaa, 1'b1);
    add_write(reg_addr(REG_GAIN), 16'hffff);
    add_write(reg_addr(REG_FORGET), 16'hffff);
    add_write(reg_addr(REG_PERIOD), 16'd511);
    add_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
    add_item(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    add_item(16'sd1, 16'sd0, '0, 1'b0);
    add_item(-16'sd1, 16'sd100, '0, 1'b0);
    add_item(16'sd12345, -16'sd300, '0, 1'b0);
    add_write(reg_addr(REG_PERIOD), 16'd0);
    add_item(16'sd0, 16'sd0, '0, 1'b0);
    add_item(16'sd0, 16'sd0, '0, 1'b0);
    add_write(reg_addr(REG_PERIOD), 16'd1);
    add_write(reg_addr(REG_GAIN), 16'h0000);
    add_write(reg_addr(REG_FORGET), 16'h0000);
    add_item(16'sh7fff, 16'sd5, 16'sd5, 1'b1);
    add_write(ADDR_SPARE_A, 16'hffff);
    add_write(ADDR_SPARE_B, 16'hffff);
    add_write(reg_addr(REG_OUT_MIN), 16'd100);
    add_write(reg_addr(REG_OUT_MAX), 16'hff9c);
    add_item(16'sh1234, 16'sh8000, 16'sd100, 1'b1);
    add_item(16'sh8000, 16'sh7fff, 16'sd100, 1'b1);
    add_write(reg_addr(REG_OUT_MIN), 16'h7fff);
    add_write(reg_addr(REG_OUT_MAX), 16'h8000);
    add_item(16'sh8000, 16'sd0, 16'sh7fff, 1'b1);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_WRITE) begin
        settle();
        write_reg(directed_steps[i].addr, directed_steps[i].value);
      end else begin
        offer_item(directed_steps[i].err, directed_steps[i].base,
                   directed_steps[i].want, directed_steps[i].typed);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase < PHASES / 3) begin
        tx_idle_pct = 22;
        rx_stall_pct = 52;
      end else if (phase < 2 * PHASES / 3) begin
        tx_idle_pct = 52;
        rx_stall_pct = 22;
      end else begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      err_mode = $urandom_range(4);
      random_setup(err_mode == 1 || err_mode == 2);
      if (phase % 5 == 1) hold_trigger++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case (err_mode)
          1: err = 16'(32767 - int'($urandom_range(3)));
          2: err = 16'(-32768 + int'($urandom_range(3)));
          3: err = 16'(int'($urandom_range(400)) - 200);
          default: err = 16'($urandom());
        endcase
        if ($urandom_range(3) == 0) base = 16'(int'($urandom_range(2000)) - 1000);
        else base = 16'($urandom());
        offer_item(err, base, '0, 1'b0);
      end
    end

    settle();
    if (fail_count == 0) $display("tb_repetitive_control_loop passed");
    else $display("tb_repetitive_control_loop failed");
    $finish;
  end

endmodule
